// ===== rtl/core/tosl_pkg.sv =====
// Shared opcodes, field widths and payload types for the timeout-ordered slot list.
package tosl_pkg;

   // Field widths fixed by the request and response formats.
   localparam int OP_W   = 2;
   localparam int SLOT_W = 10;
   localparam int ID_W   = 32;
   localparam int TICK_W = 32;

   // Request opcodes; the fourth code is unused and changes nothing.
   localparam logic [OP_W-1:0] OP_TOUCH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef logic [OP_W-1:0]   opcode_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [ID_W-1:0]   id_type;
   typedef logic [TICK_W-1:0] tick_type;

endpackage

// ===== rtl/core/tosl_spram.sv =====
// Single-port synchronous RAM with a registered read port.
module tosl_spram #(
   parameter int DEPTH = 1025,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One access per cycle: a write, or a read whose data shows up next cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/timeout_ordered_slot_list_core.sv =====
// Top level of the timeout-ordered slot list: sequencer, link memories and response register.
// A touch walks states T1 to T4 (T2 only if the slot was listed); a pop walks P1 and, if the
// list is not empty, P2; clear and no-op requests answer from idle. Requests stall until the
// sequencer is back in idle, as each link memory has a single port; a clear then sweeps the
// listed flags of all NUM_SLOTS+1 nodes.
// Reset is synchronous and active high; after it the same sweep runs while requests stall.
// The timeout register resets to zero and may be written during the sweep.
module timeout_ordered_slot_list_core #(
   parameter int NUM_SLOTS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  tosl_pkg::opcode_type req_opcode,
   input  tosl_pkg::slot_type  req_slot,
   input  tosl_pkg::id_type    req_entity_id,
   input  tosl_pkg::tick_type  req_now,
   // Response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_popped_valid,
   output tosl_pkg::id_type    rsp_popped_id,
   // Timeout register write port
   input  logic                csr_wr_en,
   input  tosl_pkg::tick_type  csr_wr_data
);

   import tosl_pkg::*;

   localparam int NODE_CNT = NUM_SLOTS + 1;
   localparam int NW       = $clog2(NODE_CNT);
   localparam int PL_W     = ID_W + TICK_W;

   localparam logic [NW-1:0] SENTINEL  = '0;
   localparam logic [NW-1:0] LAST_NODE = NW'(NUM_SLOTS);

   // Sequencer states.
   localparam logic [3:0] S_SWEEP = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_T1    = 4'd2;
   localparam logic [3:0] S_T2    = 4'd3;
   localparam logic [3:0] S_T3    = 4'd4;
   localparam logic [3:0] S_T4    = 4'd5;
   localparam logic [3:0] S_P1    = 4'd6;
   localparam logic [3:0] S_P2    = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic [NW-1:0] sweep_ff, sweep_in;
   tick_type      timeout_ff;

   // Latched request and values gathered during the walk.
   logic [NW-1:0] node_ff, node_in;
   id_type        id_ff, id_in;
   tick_type      now_ff, now_in;
   logic [NW-1:0] tail_ff, tail_in;

   // Memory ports.
   logic          nx_we, pv_we, fl_we, pl_we;
   logic [NW-1:0] nx_addr, pv_addr, fl_addr, pl_addr;
   logic [NW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
   logic          fl_wd, fl_rd;
   logic [PL_W-1:0] pl_wd, pl_rd;

   // Result hand-off.
   logic          fin_en, fin_valid;
   id_type        fin_id;
   logic          hold_ff, hold_in;
   logic          hold_valid_ff, hold_valid_in;
   id_type        hold_id_ff, hold_id_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pv_ff, rsp_pv_in;
   id_type        rsp_id_ff, rsp_id_in;
   logic          rsp_free;

   logic          accept;
   logic          slot_ok;
   logic [31:0]   node_full;
   logic [NW-1:0] req_node;
   tick_type      age;

   // Link, flag and payload memories, one entry per node.
   tosl_spram #(.DEPTH(NODE_CNT), .WIDTH(NW)) u_next_ram (
      .clock(clock), .wr_en(nx_we), .addr(nx_addr), .wr_data(nx_wd), .rd_data(nx_rd)
   );
   tosl_spram #(.DEPTH(NODE_CNT), .WIDTH(NW)) u_prev_ram (
      .clock(clock), .wr_en(pv_we), .addr(pv_addr), .wr_data(pv_wd), .rd_data(pv_rd)
   );
   tosl_spram #(.DEPTH(NODE_CNT), .WIDTH(1)) u_flag_ram (
      .clock(clock), .wr_en(fl_we), .addr(fl_addr), .wr_data(fl_wd), .rd_data(fl_rd)
   );
   tosl_spram #(.DEPTH(NODE_CNT), .WIDTH(PL_W)) u_payload_ram (
      .clock(clock), .wr_en(pl_we), .addr(pl_addr), .wr_data(pl_wd), .rd_data(pl_rd)
   );

   // Requests are taken only in idle with no result parked.
   assign req_stall = (state_ff != S_IDLE) || hold_ff;
   assign accept    = req_valid && !req_stall;

   // Slot s lives at node s+1; slots past the table are ignored.
   assign slot_ok   = 32'(req_slot) < 32'(NUM_SLOTS);
   assign node_full = 32'(req_slot) + 32'd1;
   assign req_node  = node_full[NW-1:0];

   // Wrap-safe age of the head entry.
   assign age = now_ff - pl_rd[TICK_W-1:0];

   // Sequencer: drives memory ports and produces the result.
   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      node_in   = node_ff;
      id_in     = id_ff;
      now_in    = now_ff;
      tail_in   = tail_ff;
      nx_we = 1'b0; nx_addr = SENTINEL; nx_wd = SENTINEL;
      pv_we = 1'b0; pv_addr = SENTINEL; pv_wd = SENTINEL;
      fl_we = 1'b0; fl_addr = SENTINEL; fl_wd = 1'b0;
      pl_we = 1'b0; pl_addr = SENTINEL; pl_wd = {id_ff, now_ff};
      fin_en    = 1'b0;
      fin_valid = 1'b0;
      fin_id    = '0;
      case (state_ff)
         S_SWEEP: begin
            // Drop one listed flag a cycle; node 0 comes back self-linked.
            fl_we   = 1'b1;
            fl_addr = sweep_ff;
            nx_we   = 1'b1;
            nx_addr = sweep_ff;
            pv_we   = 1'b1;
            pv_addr = sweep_ff;
            if (sweep_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + NW'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               node_in = req_node;
               id_in   = req_entity_id;
               now_in  = req_now;
               case (req_opcode)
                  OP_TOUCH: begin
                     if (slot_ok && (req_entity_id != '0)) begin
                        // Fetch the slot's flag and both links.
                        fl_addr  = req_node;
                        nx_addr  = req_node;
                        pv_addr  = req_node;
                        state_in = S_T1;
                     end else begin
                        fin_en = 1'b1;
                     end
                  end
                  OP_POP: begin
                     nx_addr  = SENTINEL;
                     state_in = S_P1;
                  end
                  OP_CLEAR: begin
                     fin_en   = 1'b1;
                     sweep_in = SENTINEL;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     fin_en = 1'b1;
                  end
               endcase
            end
         end
         S_T1: begin
            if (fl_rd) begin
               // Unlink the slot from its neighbors.
               nx_we    = 1'b1;
               nx_addr  = pv_rd;
               nx_wd    = nx_rd;
               pv_we    = 1'b1;
               pv_addr  = nx_rd;
               pv_wd    = pv_rd;
               state_in = S_T2;
            end else begin
               pv_addr  = SENTINEL;
               state_in = S_T3;
            end
         end
         S_T2: begin
            // Tail is read after the unlink has landed.
            pv_addr  = SENTINEL;
            state_in = S_T3;
         end
         S_T3: begin
            // New tail: sentinel points back to it, it points forward to the sentinel.
            tail_in  = pv_rd;
            pv_we    = 1'b1;
            pv_addr  = SENTINEL;
            pv_wd    = node_ff;
            nx_we    = 1'b1;
            nx_addr  = node_ff;
            nx_wd    = SENTINEL;
            fl_we    = 1'b1;
            fl_addr  = node_ff;
            fl_wd    = 1'b1;
            pl_we    = 1'b1;
            pl_addr  = node_ff;
            state_in = S_T4;
         end
         S_T4: begin
            // Splice the slot behind the old tail.
            pv_we    = 1'b1;
            pv_addr  = node_ff;
            pv_wd    = tail_ff;
            nx_we    = 1'b1;
            nx_addr  = tail_ff;
            nx_wd    = node_ff;
            fin_en   = 1'b1;
            state_in = S_IDLE;
         end
         S_P1: begin
            if (nx_rd == SENTINEL) begin
               fin_en   = 1'b1;
               state_in = S_IDLE;
            end else begin
               // Fetch the head's links, id and stamp.
               node_in  = nx_rd;
               nx_addr  = nx_rd;
               pv_addr  = nx_rd;
               pl_addr  = nx_rd;
               state_in = S_P2;
            end
         end
         S_P2: begin
            fin_en   = 1'b1;
            state_in = S_IDLE;
            if (age >= timeout_ff) begin
               // Expired: unlink the head and report its id.
               nx_we     = 1'b1;
               nx_addr   = pv_rd;
               nx_wd     = nx_rd;
               pv_we     = 1'b1;
               pv_addr   = nx_rd;
               pv_wd     = pv_rd;
               fl_we     = 1'b1;
               fl_addr   = node_ff;
               fin_valid = 1'b1;
               fin_id    = pl_rd[PL_W-1:TICK_W];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register, with a parking slot when the consumer stalls.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_pv_in     = rsp_pv_ff;
      rsp_id_in     = rsp_id_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      hold_id_in    = hold_id_ff;
      if (rsp_free) begin
         if (fin_en) begin
            rsp_valid_in = 1'b1;
            rsp_pv_in    = fin_valid;
            rsp_id_in    = fin_id;
         end else if (hold_ff) begin
            rsp_valid_in = 1'b1;
            rsp_pv_in    = hold_valid_ff;
            rsp_id_in    = hold_id_ff;
            hold_in      = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (fin_en) begin
         hold_in       = 1'b1;
         hold_valid_in = fin_valid;
         hold_id_in    = fin_id;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= SENTINEL;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      id_ff         <= id_in;
      now_ff        <= now_in;
      tail_ff       <= tail_in;
      hold_valid_ff <= hold_valid_in;
      hold_id_ff    <= hold_id_in;
      rsp_pv_ff     <= rsp_pv_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_valid = rsp_pv_ff;
   assign rsp_popped_id    = rsp_id_ff;

`ifndef SYNTHESIS
   // Requests stall on the cycle after reset while the flag sweep runs.
   a_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request accepted during the post-reset sweep");

   // A removed entry always carries a nonzero id, since touch ignores zero.
   a_popped_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_popped_valid) |-> (rsp_popped_id != '0))
      else $error("popped entry with zero id");

   // A new result never arrives while another one is parked.
   a_no_double_park: assert property (@(posedge clock) disable iff (reset)
      !(hold_ff && fin_en))
      else $error("result finished while a parked result waits");

   // The splice never links a slot behind itself.
   a_tail_not_self: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T4) |-> (tail_ff != node_ff))
      else $error("touched slot found as its own tail");
`endif

endmodule

// ===== tb/tosl_checker.sv =====
// Checker for the timeout-ordered slot list: predicts every response and compares it.
`timescale 1ns / 1ps
module tosl_checker #(
   parameter int NUM_SLOTS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  tosl_pkg::opcode_type req_opcode,
   input  tosl_pkg::slot_type   req_slot,
   input  tosl_pkg::id_type     req_entity_id,
   input  tosl_pkg::tick_type   req_now,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_popped_valid,
   input  tosl_pkg::id_type     rsp_popped_id,
   input  logic                 csr_wr_en,
   input  tosl_pkg::tick_type   csr_wr_data,
   output int                   failures,
   output int                   outstanding
);

   import tosl_pkg::*;

   // Node 0 is the sentinel; slot s lives in node s+1.
   localparam int NODES  = NUM_SLOTS + 1;
   localparam int LINK_W = $clog2(NODES);

   typedef logic [LINK_W-1:0] link_type;

   typedef struct packed {
      logic   popped_valid;
      id_type popped_id;
   } pop_result_type;

   // Shadow copy of the list state and the timeout register.
   link_type fwd_link   [NODES];
   link_type back_link  [NODES];
   logic     on_list    [NODES];
   id_type   slot_id    [NODES];
   tick_type slot_stamp [NODES];
   tick_type timeout_ticks;

   // Responses still owed by the block, oldest first.
   pop_result_type pending_pops [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] pop response error: %s", $time, what);
      failures++;
   endtask

   function automatic void unlink_node(input link_type node);
      link_type nxt;
      link_type prv;
      nxt = fwd_link[node];
      prv = back_link[node];
      back_link[nxt] = prv;
      fwd_link[prv] = nxt;
      on_list[node] = 1'b0;
   endfunction

   function automatic void clear_list();
      for (int n = 0; n < NODES; n++) begin
         on_list[n] = 1'b0;
      end
      fwd_link[0] = '0;
      back_link[0] = '0;
   endfunction

   // Apply one request to the shadow list and return the response it owes.
   function automatic pop_result_type apply_request(input opcode_type op, input slot_type slot,
                                                    input id_type id, input tick_type now);
      pop_result_type res;
      link_type node;
      link_type tail;
      link_type head;
      tick_type age;
      res = '0;
      case (op)
         OP_TOUCH: begin
            // A zero id leaves everything as it was.
            if (id != '0 && int'(slot) < NUM_SLOTS) begin
               node = link_type'(slot) + link_type'(1);
               if (on_list[node]) begin
                  unlink_node(node);
               end
               tail = back_link[0];
               back_link[0] = node;
               fwd_link[node] = '0;
               back_link[node] = tail;
               fwd_link[tail] = node;
               on_list[node] = 1'b1;
               slot_id[node] = id;
               slot_stamp[node] = now;
            end
         end
         OP_POP: begin
            // Only an expired head comes off; the age is taken modulo 2^32.
            head = fwd_link[0];
            if (head != '0 && on_list[head]) begin
               age = now - slot_stamp[head];
               if (age >= timeout_ticks) begin
                  unlink_node(head);
                  res.popped_valid = 1'b1;
                  res.popped_id = slot_id[head];
               end
            end
         end
         OP_CLEAR: begin
            clear_list();
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Track register writes and requests, then check responses in order.
   always @(posedge clock) begin : monitor
      pop_result_type want;
      if (reset) begin
         for (int n = 0; n < NODES; n++) begin
            fwd_link[n] = '0;
            back_link[n] = '0;
            slot_id[n] = '0;
            slot_stamp[n] = '0;
         end
         clear_list();
         timeout_ticks = '0;
         pending_pops.delete();
         failures = 0;
      end else begin
         if (csr_wr_en) begin
            timeout_ticks = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            pending_pops.push_back(apply_request(req_opcode, req_slot, req_entity_id, req_now));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pops.size() == 0) begin
               report_mismatch($sformatf("unexpected response, valid %0b id %h",
                                         rsp_popped_valid, rsp_popped_id));
            end else begin
               want = pending_pops.pop_front();
               if (rsp_popped_valid !== want.popped_valid) begin
                  report_mismatch($sformatf("popped_valid %0b, predicted %0b",
                                            rsp_popped_valid, want.popped_valid));
               end
               if (rsp_popped_id !== want.popped_id) begin
                  report_mismatch($sformatf("popped_id %h, predicted %h",
                                            rsp_popped_id, want.popped_id));
               end
            end
         end
      end
      outstanding = pending_pops.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the slot list testbench: clock, reset, request stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
   import tosl_pkg::*;

   localparam int NUM_SLOTS = 1024;
   localparam opcode_type OP_UNUSED = 2'd3;
   // Cycles without any handshake before the run is declared hung.
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_ITEMS = 125;
   localparam tick_type T0 = 32'hFFFF_FF00;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid;
   logic       req_stall;
   opcode_type req_opcode;
   slot_type   req_slot;
   id_type     req_entity_id;
   tick_type   req_now;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_popped_valid;
   id_type     rsp_popped_id;
   logic       csr_wr_en;
   tick_type   csr_wr_data;
   int         failures;
   int         outstanding;
   bit         idle_on = 1'b1;

   timeout_ordered_slot_list_core #(
      .NUM_SLOTS(NUM_SLOTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_slot        (req_slot),
      .req_entity_id   (req_entity_id),
      .req_now         (req_now),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_popped_valid(rsp_popped_valid),
      .rsp_popped_id   (rsp_popped_id),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   tosl_checker #(
      .NUM_SLOTS(NUM_SLOTS)
   ) chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_slot        (req_slot),
      .req_entity_id   (req_entity_id),
      .req_now         (req_now),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_popped_valid(rsp_popped_valid),
      .rsp_popped_id   (rsp_popped_id),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .failures        (failures),
      .outstanding     (outstanding)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Present one request at a falling edge and hold it until it is accepted.
   task automatic issue(input opcode_type op, input slot_type slot, input id_type id,
                        input tick_type now);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_slot = slot;
      req_entity_id = id;
      req_now = now;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop the request valid and wait until every response has come back.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      wait (outstanding == 0);
   endtask

   task automatic write_timeout(input tick_type value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Response back-pressure in random bursts.
   initial begin : rsp_backpressure
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall = 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // End the run if neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      tick_type phase_timeouts [9];
      tick_type tnow;
      tick_type stamp;
      slot_type pick_slot;
      id_type   pick_id;
      int       pick;

      req_valid = 1'b0;
      req_opcode = OP_TOUCH;
      req_slot = '0;
      req_entity_id = '0;
      req_now = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: empty pop, extreme slots and ids, zero id, re-touch, wrap of time.
      write_timeout(32'd100);
      issue(OP_POP, '0, '0, T0);
      issue(OP_TOUCH, 10'd0, 32'hFFFF_FFFF, T0);
      issue(OP_TOUCH, 10'd1023, 32'd1, T0 + 10);
      issue(OP_TOUCH, 10'd5, 32'd0, T0 + 20);
      issue(OP_TOUCH, 10'd7, 32'h1234_5678, T0 + 20);
      issue(OP_TOUCH, 10'd0, 32'hA5A5_A5A5, T0 + 30);
      issue(OP_POP, '0, '0, T0 + 50);
      // Age equal to the timeout counts as expired.
      issue(OP_POP, '0, '0, T0 + 110);
      issue(OP_UNUSED, 10'd3, 32'hFFFF_FFFF, '0);
      // Time has wrapped past zero here.
      issue(OP_POP, '0, '0, T0 + 300);
      issue(OP_POP, '0, '0, T0 + 300);
      issue(OP_POP, '0, '0, T0 + 300);
      // Re-touch of a slot in the middle of the list.
      issue(OP_TOUCH, 10'd3, 32'd2, 32'd0);
      issue(OP_TOUCH, 10'd4, 32'd3, 32'd0);
      issue(OP_TOUCH, 10'd5, 32'd4, 32'd0);
      issue(OP_TOUCH, 10'd4, 32'd5, 32'd1);
      issue(OP_POP, '0, '0, 32'd200);
      issue(OP_POP, '0, '0, 32'd200);
      // Clear with a slot still listed, then pop the empty list.
      issue(OP_CLEAR, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_POP, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_TOUCH, 10'd9, 32'd9, 32'hFFFF_FFFF);
      issue(OP_POP, '0, '0, 32'd99);
      // Largest timeout: only an age of all ones expires.
      settle();
      write_timeout(32'hFFFF_FFFF);
      issue(OP_TOUCH, 10'd2, 32'hDEAD_BEEF, 32'd1000);
      issue(OP_POP, '0, '0, 32'd999);
      issue(OP_TOUCH, 10'd2, 32'd4, 32'd1000);
      issue(OP_POP, '0, '0, 32'd1000);
      // Zero timeout: an age of zero expires.
      settle();
      write_timeout(32'd0);
      issue(OP_POP, '0, '0, 32'd1000);

      // Random phases, one timeout setting each; the last one runs without idling or back-pressure.
      phase_timeouts = '{32'd0, 32'd1, 32'd12, 32'd40, 32'd150, 32'hFFFF_FFFF,
                         32'h8000_0000, tick_type'($urandom), 32'd25};
      foreach (phase_timeouts[p]) begin
         settle();
         write_timeout(phase_timeouts[p]);
         idle_on = (p != 8);
         if ($urandom_range(0, 2) == 0) begin
            tnow = 32'hFFFF_FFFF - tick_type'($urandom_range(0, 600));
         end else begin
            tnow = tick_type'($urandom);
         end
         repeat (PHASE_ITEMS) begin
            // Time mostly moves forward; a few requests carry an arbitrary time.
            tnow = tnow + tick_type'($urandom_range(0, 6));
            stamp = ($urandom_range(0, 19) == 0) ? tick_type'($urandom) : tnow;
            pick_slot = ($urandom_range(0, 9) < 7) ? slot_type'($urandom_range(0, 15))
                                                   : slot_type'($urandom);
            pick_id = ($urandom_range(0, 19) == 0) ? id_type'(0) : id_type'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               issue(OP_TOUCH, pick_slot, pick_id, stamp);
            end else if (pick < 93) begin
               issue(OP_POP, pick_slot, pick_id, stamp);
            end else if (pick < 96) begin
               issue(OP_CLEAR, pick_slot, pick_id, stamp);
            end else begin
               issue(OP_UNUSED, pick_slot, pick_id, stamp);
            end
         end
      end

      // Drain, then give any stray response time to show up.
      settle();
      repeat (10) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== timeout_ordered_slot_list_core.f =====
rtl/core/tosl_pkg.sv
rtl/core/tosl_spram.sv
rtl/core/timeout_ordered_slot_list_core.sv
tb/tosl_checker.sv
tb/testbench.sv
